[hw/rtl/assert_macros.svh]
// Assertion macros used by the propagator core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TSP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`define TSP_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define TSP_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`define TSP_ASSERT_SAME(lbl, clk, rst, ante, cons)
`endif
`endif

[hw/rtl/tsp_pkg.sv]
// Types, constants and command codes of the sigma propagator
package tsp_pkg;

  localparam logic [6:0]  MAX_VISIBLE   = 7'd64;
  localparam logic [9:0]  MS_PER_SEC    = 10'd1000;
  localparam logic [32:0] F_ONE         = 33'h001000000;
  localparam int          DIV_T_STEPS   = 24;
  localparam int          DIV_N_STEPS   = 9;
  localparam int          SQRT_STEPS    = 16;
  localparam int          CNT_W         = 5;

  localparam logic [2:0] REG_BASE_GROWTH = 3'd0;
  localparam logic [2:0] REG_VIS_GAIN    = 3'd1;
  localparam logic [2:0] REG_KAPPA_GAIN  = 3'd2;
  localparam logic [2:0] REG_LEVEL       = 3'd3;
  localparam logic [2:0] REG_NOMINAL     = 3'd4;
  localparam logic [2:0] REG_INIT_SIGMA  = 3'd5;
  localparam logic [2:0] REG_VIS_ENABLE  = 3'd6;

  localparam logic [4:0] OP_NONE    = 5'd0;
  localparam logic [4:0] OP_LOAD    = 5'd1;
  localparam logic [4:0] OP_MSQ     = 5'd2;
  localparam logic [4:0] OP_MG2     = 5'd3;
  localparam logic [4:0] OP_MGLO    = 5'd4;
  localparam logic [4:0] OP_MGHI    = 5'd5;
  localparam logic [4:0] OP_DINIT_T = 5'd6;
  localparam logic [4:0] OP_DSTEP   = 5'd7;
  localparam logic [4:0] OP_VAR     = 5'd8;
  localparam logic [4:0] OP_SSTEP   = 5'd9;
  localparam logic [4:0] OP_SIGMA   = 5'd10;
  localparam logic [4:0] OP_MDEF    = 5'd11;
  localparam logic [4:0] OP_DINIT_N = 5'd12;
  localparam logic [4:0] OP_MKAP    = 5'd13;
  localparam logic [4:0] OP_FADD    = 5'd14;
  localparam logic [4:0] OP_MBF     = 5'd15;
  localparam logic [4:0] OP_GROW    = 5'd16;
  localparam logic [4:0] OP_MPL     = 5'd17;
  localparam logic [4:0] OP_RESULT  = 5'd18;

  typedef struct packed {
    logic [31:0] base_growth;
    logic [15:0] visibility_gain;
    logic [15:0] kappa_gain;
    logic [15:0] level_factor;
    logic [6:0]  nominal_visible;
    logic [31:0] initial_sigma;
    logic        visibility_enable;
  } cfg_t;

  typedef struct packed {
    logic [4:0] op;
  } cmd_t;

  typedef struct packed {
    logic start;
    logic enable;
    logic out_free;
  } stat_t;

endpackage

[hw/rtl/trajectory_sigma_propagator_core.sv]
// Sigma propagator along a trajectory: one item in, one sigma and protection
// level out. A start item loads the initial sigma; any other item grows the
// held sigma by the stored growth rate over the stamp difference through one
// shared 32x32 multiplier, a divide by 1000 at four quotient bits per step
// and a 2-bit-per-cycle square root; with visibility scaling enabled the
// growth factor adds a divide by the nominal count. The block takes one
// item at a time; the output register lets the next item be accepted while
// a result waits.
module trajectory_sigma_propagator_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // stamp_ms[31:0], visible_count[38:32], mean_kappa[54:39]
  input  logic        s_tuser,   // start_flag
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // sigma_out[31:0], protection_level[63:32]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  tsp_pkg::cfg_t  cfg;
  tsp_pkg::cmd_t  cmd;
  tsp_pkg::stat_t stat;
  logic [2:0]     reg_idx;
  logic           wr_en;
  logic [31:0]    sigma_out, protection_level;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_growth       <= 32'd65536;
      cfg.visibility_gain   <= 16'd0;
      cfg.kappa_gain        <= 16'd0;
      cfg.level_factor      <= 16'd1536;
      cfg.nominal_visible   <= 7'd8;
      cfg.initial_sigma     <= 32'd65536;
      cfg.visibility_enable <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        tsp_pkg::REG_BASE_GROWTH: cfg.base_growth       <= pwdata;
        tsp_pkg::REG_VIS_GAIN:    cfg.visibility_gain   <= pwdata[15:0];
        tsp_pkg::REG_KAPPA_GAIN:  cfg.kappa_gain        <= pwdata[15:0];
        tsp_pkg::REG_LEVEL:       cfg.level_factor      <= pwdata[15:0];
        tsp_pkg::REG_NOMINAL:     cfg.nominal_visible   <= pwdata[6:0];
        tsp_pkg::REG_INIT_SIGMA:  cfg.initial_sigma     <= pwdata;
        tsp_pkg::REG_VIS_ENABLE:  cfg.visibility_enable <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      tsp_pkg::REG_BASE_GROWTH: prdata = cfg.base_growth;
      tsp_pkg::REG_VIS_GAIN:    prdata = {16'b0, cfg.visibility_gain};
      tsp_pkg::REG_KAPPA_GAIN:  prdata = {16'b0, cfg.kappa_gain};
      tsp_pkg::REG_LEVEL:       prdata = {16'b0, cfg.level_factor};
      tsp_pkg::REG_NOMINAL:     prdata = {25'b0, cfg.nominal_visible};
      tsp_pkg::REG_INIT_SIGMA:  prdata = cfg.initial_sigma;
      tsp_pkg::REG_VIS_ENABLE:  prdata = {31'b0, cfg.visibility_enable};
      default:                  prdata = 32'd0;
    endcase
  end

  tsp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tsp_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .stat      (stat),
    .in_start  (s_tuser),
    .in_stamp  (s_tdata[31:0]),
    .in_vis    (s_tdata[38:32]),
    .in_kappa  (s_tdata[54:39]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_sigma (sigma_out),
    .out_level (protection_level)
  );

  assign m_tdata = {protection_level, sigma_out};

`include "assert_macros.svh"

  `TSP_ASSERT_NEXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready)
  `TSP_ASSERT_SAME(a_result_while_busy, clk, rst, $rose(m_tvalid), !$past(s_tready))
  `TSP_ASSERT_NEXT(a_no_instant_result, clk, rst, s_tvalid && s_tready, !$rose(m_tvalid))

endmodule

[hw/rtl/tsp_ctrl.sv]
// Controller state machine sequencing the propagator datapath
module tsp_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  tsp_pkg::stat_t stat,
  output tsp_pkg::cmd_t  cmd
);

  localparam logic [4:0] ST_IDLE    = 5'd0;
  localparam logic [4:0] ST_MSQ     = 5'd1;
  localparam logic [4:0] ST_MG2     = 5'd2;
  localparam logic [4:0] ST_MGLO    = 5'd3;
  localparam logic [4:0] ST_MGHI    = 5'd4;
  localparam logic [4:0] ST_DINIT_T = 5'd5;
  localparam logic [4:0] ST_DSTEP_T = 5'd6;
  localparam logic [4:0] ST_VAR     = 5'd7;
  localparam logic [4:0] ST_SSTEP   = 5'd8;
  localparam logic [4:0] ST_SIGMA   = 5'd9;
  localparam logic [4:0] ST_MDEF    = 5'd10;
  localparam logic [4:0] ST_DINIT_N = 5'd11;
  localparam logic [4:0] ST_DSTEP_N = 5'd12;
  localparam logic [4:0] ST_MKAP    = 5'd13;
  localparam logic [4:0] ST_FADD    = 5'd14;
  localparam logic [4:0] ST_MBF     = 5'd15;
  localparam logic [4:0] ST_GROW    = 5'd16;
  localparam logic [4:0] ST_MPL     = 5'd17;
  localparam logic [4:0] ST_RESULT  = 5'd18;

  logic [4:0] state, state_next;
  logic [tsp_pkg::CNT_W-1:0] cnt, cnt_next;

  always_comb begin
    state_next = state;
    cnt_next   = '0;
    cmd.op     = tsp_pkg::OP_NONE;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op     = tsp_pkg::OP_LOAD;
          state_next = ST_MSQ;
        end
      end
      ST_MSQ: begin
        cmd.op     = tsp_pkg::OP_MSQ;
        state_next = stat.start ? ST_SIGMA : ST_MG2;
      end
      ST_MG2: begin
        cmd.op     = tsp_pkg::OP_MG2;
        state_next = ST_MGLO;
      end
      ST_MGLO: begin
        cmd.op     = tsp_pkg::OP_MGLO;
        state_next = ST_MGHI;
      end
      ST_MGHI: begin
        cmd.op     = tsp_pkg::OP_MGHI;
        state_next = ST_DINIT_T;
      end
      ST_DINIT_T: begin
        cmd.op     = tsp_pkg::OP_DINIT_T;
        state_next = ST_DSTEP_T;
      end
      ST_DSTEP_T: begin
        cmd.op = tsp_pkg::OP_DSTEP;
        if (cnt == tsp_pkg::CNT_W'(tsp_pkg::DIV_T_STEPS - 1)) begin
          state_next = ST_VAR;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_VAR: begin
        cmd.op     = tsp_pkg::OP_VAR;
        state_next = ST_SSTEP;
      end
      ST_SSTEP: begin
        cmd.op = tsp_pkg::OP_SSTEP;
        if (cnt == tsp_pkg::CNT_W'(tsp_pkg::SQRT_STEPS - 1)) begin
          state_next = ST_SIGMA;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_SIGMA: begin
        cmd.op     = tsp_pkg::OP_SIGMA;
        state_next = stat.enable ? ST_MDEF : ST_GROW;
      end
      ST_MDEF: begin
        cmd.op     = tsp_pkg::OP_MDEF;
        state_next = ST_DINIT_N;
      end
      ST_DINIT_N: begin
        cmd.op     = tsp_pkg::OP_DINIT_N;
        state_next = ST_DSTEP_N;
      end
      ST_DSTEP_N: begin
        cmd.op = tsp_pkg::OP_DSTEP;
        if (cnt == tsp_pkg::CNT_W'(tsp_pkg::DIV_N_STEPS - 1)) begin
          state_next = ST_MKAP;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_MKAP: begin
        cmd.op     = tsp_pkg::OP_MKAP;
        state_next = ST_FADD;
      end
      ST_FADD: begin
        cmd.op     = tsp_pkg::OP_FADD;
        state_next = ST_MBF;
      end
      ST_MBF: begin
        cmd.op     = tsp_pkg::OP_MBF;
        state_next = ST_GROW;
      end
      ST_GROW: begin
        cmd.op     = tsp_pkg::OP_GROW;
        state_next = ST_MPL;
      end
      ST_MPL: begin
        cmd.op     = tsp_pkg::OP_MPL;
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (stat.out_free) begin
          cmd.op     = tsp_pkg::OP_RESULT;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

[hw/rtl/tsp_datapath.sv]
// Datapath: shared multiplier, divider, square root and propagation state
module tsp_datapath (
  input  logic           clk,
  input  logic           rst,
  input  tsp_pkg::cfg_t  cfg,
  input  tsp_pkg::cmd_t  cmd,
  output tsp_pkg::stat_t stat,
  input  logic           in_start,
  input  logic [31:0]    in_stamp,
  input  logic [6:0]     in_vis,
  input  logic [15:0]    in_kappa,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [31:0]    out_sigma,
  output logic [31:0]    out_level
);

  logic [31:0] sigma_reg, prev_stamp, prev_growth;
  logic        start_q, back;
  logic [31:0] stamp_q, delta;
  logic [6:0]  vis_q;
  logic [15:0] kappa_q;
  logic [63:0] p, s2, acc, sq_val;
  logic [31:0] g2hi, root, sigma, growth;
  logic [95:0] dq;
  logic [9:0]  dr, dd;
  logic [32:0] sq_rem;
  logic [32:0] fsum;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  always_comb begin
    mul_a = sigma_reg;
    mul_b = sigma_reg;
    case (cmd.op)
      tsp_pkg::OP_MG2: begin
        mul_a = prev_growth;
        mul_b = prev_growth;
      end
      tsp_pkg::OP_MGLO: begin
        mul_a = p[31:0];
        mul_b = delta;
      end
      tsp_pkg::OP_MGHI: begin
        mul_a = g2hi;
        mul_b = delta;
      end
      tsp_pkg::OP_MDEF: begin
        mul_a = {16'b0, cfg.visibility_gain};
        mul_b = {25'b0, def_use};
      end
      tsp_pkg::OP_MKAP: begin
        mul_a = {16'b0, cfg.kappa_gain};
        mul_b = {16'b0, kappa_q};
      end
      tsp_pkg::OP_MBF: begin
        mul_a = cfg.base_growth;
        mul_b = fsum[31:0];
      end
      tsp_pkg::OP_MPL: begin
        mul_a = {16'b0, cfg.level_factor};
        mul_b = sigma;
      end
      default: begin
        mul_a = sigma_reg;
        mul_b = sigma_reg;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // visibility deficit
  logic [6:0] nom_s, vis_s, def_use;
  logic       def_ok;
  assign nom_s   = (cfg.nominal_visible > tsp_pkg::MAX_VISIBLE) ?
                   tsp_pkg::MAX_VISIBLE : cfg.nominal_visible;
  assign vis_s   = (vis_q > tsp_pkg::MAX_VISIBLE) ? tsp_pkg::MAX_VISIBLE : vis_q;
  assign def_ok  = (nom_s != 7'd0) && (vis_s < nom_s);
  assign def_use = def_ok ? (nom_s - vis_s) : 7'd0;

  // restoring divider, four quotient bits per step
  logic [95:0] dq_next;
  logic [9:0]  dr_next;
  always_comb begin
    logic [10:0] r_ext;
    dq_next = dq;
    dr_next = dr;
    for (int i = 0; i < 4; i++) begin
      r_ext   = {dr_next, dq_next[95]};
      dq_next = {dq_next[94:0], 1'b0};
      if (r_ext >= {1'b0, dd}) begin
        r_ext      = r_ext - {1'b0, dd};
        dq_next[0] = 1'b1;
      end
      dr_next = r_ext[9:0];
    end
  end

  // square root, two result bits per step
  logic [63:0] sq_val_next;
  logic [32:0] sq_rem_next;
  logic [31:0] root_next;
  always_comb begin
    logic [34:0] rem_s, trial;
    sq_val_next = sq_val;
    sq_rem_next = sq_rem;
    root_next   = root;
    for (int i = 0; i < 2; i++) begin
      rem_s       = {sq_rem_next, sq_val_next[63:62]};
      sq_val_next = {sq_val_next[61:0], 2'b00};
      trial       = {1'b0, root_next, 2'b01};
      if (rem_s >= trial) begin
        rem_s     = rem_s - trial;
        root_next = {root_next[30:0], 1'b1};
      end else begin
        root_next = {root_next[30:0], 1'b0};
      end
      sq_rem_next = rem_s[32:0];
    end
  end

  // variance from held sigma and growth term
  logic [63:0] t_sat, variance;
  logic [64:0] vsum;
  assign t_sat    = (dq[95:64] != 32'd0) ? '1 : dq[63:0];
  assign vsum     = {1'b0, s2} + {1'b0, t_sat};
  assign variance = back ? ((t_sat >= s2) ? 64'd0 : (s2 - t_sat)) :
                    (vsum[64] ? '1 : vsum[63:0]);

  // growth for the next interval
  logic [64:0] gsum;
  logic [40:0] gshift;
  logic [31:0] growth_calc;
  assign gsum        = {1'b0, p} + (fsum[32] ? {1'b0, cfg.base_growth, 32'b0} : 65'd0);
  assign gshift      = gsum[64:24];
  assign growth_calc = !cfg.visibility_enable ? cfg.base_growth :
                       ((gshift[40:32] != 9'd0) ? '1 : gshift[31:0]);

  logic [27:0] def_term;
  assign def_term = def_ok ? dq[27:0] : 28'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      sigma_reg   <= '0;
      prev_stamp  <= '0;
      prev_growth <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.op == tsp_pkg::OP_RESULT) begin
        out_valid   <= 1'b1;
        sigma_reg   <= sigma;
        prev_stamp  <= stamp_q;
        prev_growth <= growth;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      tsp_pkg::OP_LOAD: begin
        start_q <= in_start;
        stamp_q <= in_stamp;
        vis_q   <= in_vis;
        kappa_q <= in_kappa;
        back    <= (in_stamp < prev_stamp);
        delta   <= (in_stamp < prev_stamp) ? (prev_stamp - in_stamp) :
                   (in_stamp - prev_stamp);
      end
      tsp_pkg::OP_MSQ: begin
        p <= mul_p;
      end
      tsp_pkg::OP_MG2: begin
        s2 <= p;
        p  <= mul_p;
      end
      tsp_pkg::OP_MGLO: begin
        g2hi <= p[63:32];
        p    <= mul_p;
      end
      tsp_pkg::OP_MGHI: begin
        acc <= p;
        p   <= mul_p;
      end
      tsp_pkg::OP_DINIT_T: begin
        dq <= {32'b0, acc} + {p, 32'b0};
        dr <= '0;
        dd <= tsp_pkg::MS_PER_SEC;
      end
      tsp_pkg::OP_DSTEP: begin
        dq <= dq_next;
        dr <= dr_next;
      end
      tsp_pkg::OP_VAR: begin
        sq_val <= variance;
        sq_rem <= '0;
        root   <= '0;
      end
      tsp_pkg::OP_SSTEP: begin
        sq_val <= sq_val_next;
        sq_rem <= sq_rem_next;
        root   <= root_next;
      end
      tsp_pkg::OP_SIGMA: begin
        sigma <= start_q ? cfg.initial_sigma : root;
      end
      tsp_pkg::OP_MDEF: begin
        p <= mul_p;
      end
      tsp_pkg::OP_DINIT_N: begin
        dq <= {2'b0, p[21:0], 12'b0, 60'b0};
        dr <= '0;
        dd <= {3'b0, nom_s};
      end
      tsp_pkg::OP_MKAP: begin
        fsum <= tsp_pkg::F_ONE + {5'b0, def_term};
        p    <= mul_p;
      end
      tsp_pkg::OP_FADD: begin
        fsum <= fsum + {1'b0, p[31:0]};
      end
      tsp_pkg::OP_MBF: begin
        p <= mul_p;
      end
      tsp_pkg::OP_GROW: begin
        growth <= growth_calc;
      end
      tsp_pkg::OP_MPL: begin
        p <= mul_p;
      end
      tsp_pkg::OP_RESULT: begin
        out_sigma <= sigma;
        out_level <= (p[47:40] != 8'd0) ? '1 : p[39:8];
      end
      default: begin
      end
    endcase
  end

  assign stat.start    = start_q;
  assign stat.enable   = cfg.visibility_enable;
  assign stat.out_free = !out_valid || out_ready;

endmodule
